@@ design/contiguous_memory_allocator_top_macros.svh @@
// Assertion macros shared by the allocator design files.
// Depends on nothing; included by files that assert.
`ifndef CONTIGUOUS_MEMORY_ALLOCATOR_TOP_MACROS_SVH
`define CONTIGUOUS_MEMORY_ALLOCATOR_TOP_MACROS_SVH
// implication checked on every clock, off during reset
`define CMA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define CMA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ design/cma_pkg.sv @@
// Package of the contiguous allocator: sizes, fit, status and opcode codes, entry types.
// Depends on nothing.
package cma_pkg;
  localparam int NumHoles  = 16;
  localparam int NumAllocs = 16;
  localparam int AddrBits  = 20;
  localparam int SizeBits  = AddrBits + 1;
  localparam int HIdxBits  = $clog2(NumHoles);
  localparam int AIdxBits  = $clog2(NumAllocs);

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0, OP_RELEASE = 2'd1, OP_COMPACT = 2'd2, OP_NONE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0, FIT_BEST = 2'd1, FIT_WORST = 2'd2, FIT_OTHER = 2'd3
  } fit_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NOMEM = 3'd1, ST_ZERO = 3'd2, ST_COMPACT = 3'd3,
    ST_UNKNOWN = 3'd4, ST_FULL = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [7:0]          process_id;
    logic [SizeBits-1:0] request_size;
    logic [1:0]          fit_mode;
  } req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [AddrBits-1:0] block_start;
    logic [AddrBits-1:0] block_end;
    logic [SizeBits-1:0] free_units;
  } rsp_t;

  // hole entry: start, size
  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [SizeBits-1:0] size;
  } hole_t;

  // allocation entry: owner, start, size
  typedef struct packed {
    logic [7:0]          owner;
    logic [AddrBits-1:0] start;
    logic [SizeBits-1:0] size;
  } alloc_t;
endpackage

@@ design/cma_stream_if.sv @@
// Valid/ready stream interfaces, each carrying one payload type.
// Depends on cma_pkg for the payload types.
interface cma_req_if;
  import cma_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cma_rsp_if;
  import cma_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/cma_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module cma_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ design/contiguous_memory_allocator_top.sv @@
// Top level of the contiguous allocator: sequencer around two table RAMs.
// Depends on cma_pkg, cma_stream_if, cma_ram and the assertion macros.
`include "contiguous_memory_allocator_top_macros.svh"
// One command at a time. The hole and allocation tables sit in two RAMs with registered
// reads and are scanned one entry per cycle, except that a compact stops its allocation
// walk to rewrite each live allocation. A request picks the lowest free allocation slot,
// scans the hole RAM, then decides, writes back and responds; it responds after the scan
// when no hole fits, and at once when it is refused for too little free memory, a zero
// size or a full table; the unused opcode is also answered at once. A release searches
// for the owner's allocation, then scans the hole RAM, decides, writes back, merges and
// responds; it responds after the hole scan when the hole table is full, and after the
// whole allocation search for an unknown id. A compact walks the allocations and moves
// each live one to the front, then rewrites the hole table. The result waits in an
// output register; the next request is taken once that register is free. After reset
// and after each total_size write, the S_HCLR state rewrites the first hole entry
// before requests are taken again; a total_size write is taken only while idle.
module contiguous_memory_allocator_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cma_pkg::SizeBits-1:0] cfg_wdata_i,
  cma_req_if.sink                    req_i,
  cma_rsp_if.source                  rsp_o
);
  import cma_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ASCAN, S_AWAIT, S_HSCAN, S_HLAST, S_REQ_WR, S_REL_WR,
    S_REL_MRG, S_CMP_SCAN, S_CMP_WR, S_HCLR, S_DONE
  } state_e;

  localparam logic [SizeBits-1:0] MaxTotal = SizeBits'(1) << AddrBits;

  state_e              state_q;
  req_t                cmd_q;
  logic [SizeBits-1:0] total_q, free_q;
  logic [NumHoles-1:0] hvalid_q;
  logic [NumAllocs-1:0] avalid_q;
  logic [AIdxBits:0]   aidx_q;
  logic [HIdxBits:0]   hidx_q;
  logic [AIdxBits-1:0] aslot_q;
  alloc_t              aent_q;
  logic [HIdxBits-1:0] pick_q, left_q, right_q, spare_q;
  logic                phave_q, lhave_q, rhave_q, shave_q;
  hole_t               pent_q, lent_q, rent_q;
  logic [AddrBits-1:0] front_q;
  logic                rsp_valid_q;
  rsp_t                rsp_q;
  // hole rewrite after reset or a total_size write gives no result
  logic                cfg_pending_q;

  // hole RAM ports
  logic                h_we;
  logic [HIdxBits-1:0] h_waddr, h_raddr;
  hole_t               h_wdata, h_rdata;
  // allocation RAM ports
  logic                a_we;
  logic [AIdxBits-1:0] a_waddr, a_raddr;
  alloc_t              a_wdata, a_rdata;

  cma_ram #(.Width($bits(hole_t)), .Depth(NumHoles)) u_hole_ram (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(h_raddr), .rdata_o(h_rdata)
  );
  cma_ram #(.Width($bits(alloc_t)), .Depth(NumAllocs)) u_alloc_ram (
    .clk_i, .we_i(a_we), .waddr_i(a_waddr), .wdata_i(a_wdata),
    .raddr_i(a_raddr), .rdata_o(a_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE) && !rsp_valid_q && !cfg_we_i;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // index of the entry read last cycle, and the RAM read addresses
  logic [HIdxBits-1:0] hprev;
  logic [AIdxBits-1:0] aprev;
  assign hprev = hidx_q[HIdxBits-1:0] - HIdxBits'(1);
  assign aprev = aidx_q[AIdxBits-1:0] - AIdxBits'(1);
  assign h_raddr = hidx_q[HIdxBits-1:0];
  assign a_raddr = aidx_q[AIdxBits-1:0];

  // lowest free allocation slot
  logic [AIdxBits-1:0] free_slot;
  always_comb begin
    free_slot = '0;
    for (int i = NumAllocs - 1; i >= 0; i--) begin
      if (!avalid_q[i]) free_slot = AIdxBits'(i);
    end
  end

  // fit comparison of the entry just read against the current pick
  logic hv_cur, fits, better;
  always_comb begin
    hv_cur = hvalid_q[hprev];
    fits   = hv_cur && (h_rdata.size >= cmd_q.request_size);
    case (cmd_q.fit_mode)
      FIT_BEST:  better = (h_rdata.size < pent_q.size) ||
                 (h_rdata.size == pent_q.size && h_rdata.start < pent_q.start);
      FIT_WORST: better = (h_rdata.size > pent_q.size) ||
                 (h_rdata.size == pent_q.size && h_rdata.start < pent_q.start);
      default:   better = h_rdata.start < pent_q.start;
    endcase
  end

  // release adjacency of the entry just read
  logic [SizeBits:0] hend, aend;
  assign hend = {1'b0, h_rdata.size} + (SizeBits+1)'(h_rdata.start);
  assign aend = {1'b0, aent_q.size} + (SizeBits+1)'(aent_q.start);

  // clamped configuration value
  logic [SizeBits-1:0] cfg_clamped;
  assign cfg_clamped = (cfg_wdata_i == '0) ? SizeBits'(1) :
                       (cfg_wdata_i > MaxTotal) ? MaxTotal : cfg_wdata_i;

  // RAM writes decided by state
  always_comb begin
    h_we = 1'b0; h_waddr = '0; h_wdata = '0;
    a_we = 1'b0; a_waddr = '0; a_wdata = '0;
    unique case (state_q)
      S_REQ_WR: begin
        h_we = 1'b1; h_waddr = pick_q;
        h_wdata.start = pent_q.start + cmd_q.request_size[AddrBits-1:0];
        h_wdata.size  = pent_q.size - cmd_q.request_size;
        a_we = 1'b1; a_waddr = aslot_q;
        a_wdata.owner = cmd_q.process_id;
        a_wdata.start = pent_q.start;
        a_wdata.size  = cmd_q.request_size;
      end
      S_REL_WR: begin
        h_we = 1'b1;
        if (lhave_q) begin
          h_waddr = left_q;
          h_wdata.start = lent_q.start;
          h_wdata.size  = lent_q.size + aent_q.size + (rhave_q ? rent_q.size : '0);
        end else if (rhave_q) begin
          h_waddr = right_q;
          h_wdata.start = aent_q.start;
          h_wdata.size  = rent_q.size + aent_q.size;
        end else begin
          h_waddr = spare_q;
          h_wdata.start = aent_q.start;
          h_wdata.size  = aent_q.size;
        end
      end
      S_CMP_WR: begin
        a_we = 1'b1; a_waddr = aslot_q;
        a_wdata.owner = aent_q.owner;
        a_wdata.start = front_q;
        a_wdata.size  = aent_q.size;
      end
      S_HCLR: begin
        h_we = 1'b1; h_waddr = '0;
        h_wdata.start = front_q;
        h_wdata.size  = free_q;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_HCLR;
      cfg_pending_q <= 1'b1;
      total_q       <= MaxTotal;
      free_q        <= MaxTotal;
      hvalid_q      <= '0;
      avalid_q      <= '0;
      rsp_valid_q   <= 1'b0;
      aidx_q <= '0; hidx_q <= '0; aslot_q <= '0;
      phave_q <= 1'b0; lhave_q <= 1'b0; rhave_q <= 1'b0; shave_q <= 1'b0;
      pick_q <= '0; left_q <= '0; right_q <= '0; spare_q <= '0;
      front_q <= '0;
    end else begin
      if (rsp_valid_q && rsp_o.ready) rsp_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cfg_we_i) begin
            total_q       <= cfg_clamped;
            free_q        <= cfg_clamped;
            avalid_q      <= '0;
            hvalid_q      <= '0;
            cfg_pending_q <= 1'b1;
            state_q       <= S_HCLR;
            front_q       <= '0;
          end else if (req_i.valid && req_i.ready) begin
            cmd_q    <= req_i.data;
            aidx_q   <= '0;
            hidx_q   <= '0;
            phave_q  <= 1'b0; lhave_q <= 1'b0; rhave_q <= 1'b0; shave_q <= 1'b0;
            front_q  <= '0;
            unique case (req_i.data.opcode)
              OP_REQUEST: begin
                if (free_q < req_i.data.request_size) begin
                  rsp_q <= '{ST_NOMEM, '0, '0, free_q}; state_q <= S_DONE;
                end else if (req_i.data.request_size == '0) begin
                  rsp_q <= '{ST_ZERO, '0, '0, free_q}; state_q <= S_DONE;
                end else if (&avalid_q) begin
                  rsp_q <= '{ST_FULL, '0, '0, free_q}; state_q <= S_DONE;
                end else state_q <= S_ASCAN;
              end
              OP_RELEASE: state_q <= S_ASCAN;
              OP_COMPACT: state_q <= S_CMP_SCAN;
              default: begin
                rsp_q <= '{ST_OK, '0, '0, free_q}; state_q <= S_DONE;
              end
            endcase
          end
        end
        // find lowest free slot (request) or lowest slot owned by pid (release)
        S_ASCAN: begin
          if (cmd_q.opcode == OP_REQUEST) begin
            aslot_q <= free_slot;
            state_q <= S_HSCAN;
          end else begin
            if (aidx_q != '0 && avalid_q[aprev] && a_rdata.owner == cmd_q.process_id) begin
              aslot_q <= aprev; aent_q <= a_rdata;
              state_q <= S_HSCAN;
            end else if (aidx_q == (AIdxBits+1)'(NumAllocs)) begin
              rsp_q <= '{ST_UNKNOWN, '0, '0, free_q}; state_q <= S_DONE;
            end else aidx_q <= aidx_q + (AIdxBits+1)'(1);
          end
        end
        // one hole entry per cycle; data for index hidx_q-1 arrives
        S_HSCAN: begin
          if (hidx_q != '0) begin
            if (cmd_q.opcode == OP_REQUEST) begin
              if (fits && (!phave_q || better)) begin
                phave_q <= 1'b1; pick_q <= hprev; pent_q <= h_rdata;
              end
            end else begin
              if (!hv_cur) begin
                if (!shave_q) begin shave_q <= 1'b1; spare_q <= hprev; end
              end else if (hend == (SizeBits+1)'(aent_q.start)) begin
                lhave_q <= 1'b1; left_q <= hprev; lent_q <= h_rdata;
              end else if (h_rdata.start == aend[AddrBits-1:0] &&
                           aend[SizeBits:AddrBits] == '0) begin
                rhave_q <= 1'b1; right_q <= hprev; rent_q <= h_rdata;
              end
            end
          end
          if (hidx_q == (HIdxBits+1)'(NumHoles)) state_q <= S_HLAST;
          else hidx_q <= hidx_q + (HIdxBits+1)'(1);
        end
        S_HLAST: begin
          if (cmd_q.opcode == OP_REQUEST) begin
            if (!phave_q) begin
              rsp_q <= '{ST_COMPACT, '0, '0, free_q}; state_q <= S_DONE;
            end else state_q <= S_REQ_WR;
          end else begin
            if (!lhave_q && !rhave_q && !shave_q) begin
              rsp_q <= '{ST_FULL, '0, '0, free_q}; state_q <= S_DONE;
            end else state_q <= S_REL_WR;
          end
        end
        S_REQ_WR: begin
          avalid_q[aslot_q] <= 1'b1;
          if (pent_q.size == cmd_q.request_size) hvalid_q[pick_q] <= 1'b0;
          free_q <= free_q - cmd_q.request_size;
          rsp_q <= '{ST_OK, pent_q.start,
                     pent_q.start + cmd_q.request_size[AddrBits-1:0] - AddrBits'(1),
                     free_q - cmd_q.request_size};
          state_q <= S_DONE;
        end
        S_REL_WR: begin
          avalid_q[aslot_q] <= 1'b0;
          if (lhave_q && rhave_q) hvalid_q[right_q] <= 1'b0;
          else if (!lhave_q && !rhave_q) hvalid_q[spare_q] <= 1'b1;
          free_q <= free_q + aent_q.size;
          rsp_q <= '{ST_OK, aent_q.start,
                     aent_q.start + aent_q.size[AddrBits-1:0] - AddrBits'(1),
                     free_q + aent_q.size};
          state_q <= S_REL_MRG;
        end
        S_REL_MRG: state_q <= S_DONE;
        // walk allocations, rewrite starts; read data is registered
        S_CMP_SCAN: begin
          if (aidx_q != '0 && avalid_q[aprev]) begin
            aslot_q <= aprev; aent_q <= a_rdata; state_q <= S_CMP_WR;
          end else if (aidx_q == (AIdxBits+1)'(NumAllocs)) begin
            state_q <= S_HCLR;
          end else aidx_q <= aidx_q + (AIdxBits+1)'(1);
        end
        S_CMP_WR: begin
          front_q <= front_q + aent_q.size[AddrBits-1:0];
          if (aidx_q == (AIdxBits+1)'(NumAllocs)) begin
            state_q <= S_HCLR;
          end else begin
            aidx_q <= aidx_q + (AIdxBits+1)'(1);
            state_q <= S_CMP_SCAN;
          end
        end
        // single hole at front_q; idle again after a rewrite, else the compact result
        S_HCLR: begin
          hvalid_q <= {{(NumHoles-1){1'b0}}, free_q != '0};
          if (cfg_pending_q) begin
            cfg_pending_q <= 1'b0;
            state_q <= S_IDLE;
          end else begin
            rsp_q <= '{ST_OK, '0, '0, free_q};
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          rsp_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `CMA_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, req_i.ready, state_q == S_IDLE && !rsp_valid_q)
  `CMA_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, req_i.valid && req_i.ready, state_q != S_IDLE)
  `CMA_ASSERT_IMP(a_free_le_total, clk_i, rst_ni, 1'b1, free_q <= total_q)
endmodule

@@ tb/cma_alloc_checker.sv @@
// Checker for the contiguous allocator: watches the request, response and config ports.
// It predicts each response and compares it field by field. Depends on cma_pkg and cma_stream_if.
`timescale 1ns / 100ps
module cma_alloc_checker
  import cma_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SizeBits-1:0] cfg_wdata_i,
  cma_req_if                  req_i,
  cma_rsp_if                  rsp_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  localparam int unsigned MemLimit = 1 << AddrBits;

  // shadow copy of the allocator tables
  int unsigned mem_size;
  int unsigned hole_base [NumHoles];
  int unsigned hole_len  [NumHoles];
  bit          hole_used [NumHoles];
  int unsigned blk_owner [NumAllocs];
  int unsigned blk_base  [NumAllocs];
  int unsigned blk_len   [NumAllocs];
  bit          blk_used  [NumAllocs];
  int unsigned free_units;

  rsp_t expected_rsps[$];

  function automatic void clear_tables(int unsigned size_req);
    mem_size = (size_req == 0) ? 1 : (size_req > MemLimit ? MemLimit : size_req);
    foreach (hole_used[i]) begin
      hole_base[i] = 0;
      hole_len[i]  = 0;
      hole_used[i] = 0;
    end
    foreach (blk_used[i]) blk_used[i] = 0;
    hole_len[0]  = mem_size;
    hole_used[0] = 1;
    free_units   = mem_size;
  endfunction

  // hole choice by fit mode; ties go to the lower start address
  function automatic int choose_hole(int unsigned need, logic [1:0] mode);
    int pick;
    bit take;
    pick = -1;
    for (int i = 0; i < NumHoles; i++) begin
      if (!hole_used[i] || hole_len[i] < need) continue;
      if (pick < 0) begin
        pick = i;
        continue;
      end
      if (mode == FIT_BEST)
        take = hole_len[i] < hole_len[pick] ||
               (hole_len[i] == hole_len[pick] && hole_base[i] < hole_base[pick]);
      else if (mode == FIT_WORST)
        take = hole_len[i] > hole_len[pick] ||
               (hole_len[i] == hole_len[pick] && hole_base[i] < hole_base[pick]);
      else
        take = hole_base[i] < hole_base[pick];
      if (take) pick = i;
    end
    return pick;
  endfunction

  function automatic rsp_t allocator_step(req_t rq);
    rsp_t r;
    int slot, h, left, right, spare;
    int unsigned need, bs, be, st, sz, front;
    status_e stat;
    slot = -1;
    left = -1;
    right = -1;
    spare = -1;
    bs = 0;
    be = 0;
    stat = ST_OK;
    need = rq.request_size;
    case (opcode_e'(rq.opcode))
      OP_REQUEST: begin
        for (int i = 0; i < NumAllocs; i++)
          if (!blk_used[i] && slot < 0) slot = i;
        if (free_units < need) stat = ST_NOMEM;
        else if (need == 0) stat = ST_ZERO;
        else if (slot < 0) stat = ST_FULL;
        else begin
          h = choose_hole(need, rq.fit_mode);
          if (h < 0) stat = ST_COMPACT;
          else begin
            blk_used[slot]  = 1;
            blk_owner[slot] = rq.process_id;
            blk_base[slot]  = hole_base[h];
            blk_len[slot]   = need;
            hole_base[h] += need;
            hole_len[h]  -= need;
            if (hole_len[h] == 0) hole_used[h] = 0;
            free_units -= need;
            bs = blk_base[slot];
            be = bs + need - 1;
          end
        end
      end
      OP_RELEASE: begin
        for (int i = 0; i < NumAllocs; i++)
          if (blk_used[i] && blk_owner[i] == rq.process_id && slot < 0) slot = i;
        if (slot < 0) stat = ST_UNKNOWN;
        else begin
          st = blk_base[slot];
          sz = blk_len[slot];
          for (int i = 0; i < NumHoles; i++) begin
            if (!hole_used[i]) begin
              if (spare < 0) spare = i;
            end else if (hole_base[i] + hole_len[i] == st) left = i;
            else if (hole_base[i] == st + sz) right = i;
          end
          if (left >= 0 && right >= 0) begin
            hole_len[left] += sz + hole_len[right];
            hole_used[right] = 0;
          end else if (left >= 0) begin
            hole_len[left] += sz;
          end else if (right >= 0) begin
            hole_base[right] = st;
            hole_len[right] += sz;
          end else if (spare >= 0) begin
            hole_used[spare] = 1;
            hole_base[spare] = st;
            hole_len[spare]  = sz;
          end else stat = ST_FULL;
          if (stat == ST_OK) begin
            blk_used[slot] = 0;
            free_units += sz;
            bs = st;
            be = st + sz - 1;
          end
        end
      end
      OP_COMPACT: begin
        // pack allocations from address 0 in slot order
        front = 0;
        for (int i = 0; i < NumAllocs; i++)
          if (blk_used[i]) begin
            blk_base[i] = front;
            front += blk_len[i];
          end
        foreach (hole_used[i]) begin
          hole_base[i] = 0;
          hole_len[i]  = 0;
          hole_used[i] = 0;
        end
        if (free_units > 0) begin
          hole_used[0] = 1;
          hole_base[0] = front;
          hole_len[0]  = free_units;
        end
      end
      default: ;
    endcase
    r.status      = stat;
    r.block_start = bs[AddrBits-1:0];
    r.block_end   = be[AddrBits-1:0];
    r.free_units  = free_units[SizeBits-1:0];
    return r;
  endfunction

  // sample both channels and the config port at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      clear_tables(MemLimit);
      expected_rsps.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) clear_tables(cfg_wdata_i);
      if (req_i.valid && req_i.ready) expected_rsps.push_back(allocator_step(req_i.data));
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding: %p", rsp_i.data);
          errs++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_i.data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_i.data.status);
            errs++;
          end
          if (rsp_i.data.block_start !== want.block_start) begin
            $error("block_start: expected %0d, got %0d",
                   want.block_start, rsp_i.data.block_start);
            errs++;
          end
          if (rsp_i.data.block_end !== want.block_end) begin
            $error("block_end: expected %0d, got %0d", want.block_end, rsp_i.data.block_end);
            errs++;
          end
          if (rsp_i.data.free_units !== want.free_units) begin
            $error("free_units: expected %0d, got %0d",
                   want.free_units, rsp_i.data.free_units);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= expected_rsps.size();
    end
  end
endmodule

@@ tb/tb_contiguous_memory_allocator_top.sv @@
// Testbench top for the contiguous allocator: clock, reset, stimulus and verdict.
// Depends on cma_pkg, cma_stream_if, the allocator top and cma_alloc_checker.
`timescale 1ns / 100ps
module tb_contiguous_memory_allocator_top;
  import cma_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int RandomItems = 1500;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [SizeBits-1:0] cfg_wdata_i;
  int                  fail_count;
  int                  pending;
  int                  idle_cycles;
  bit                  no_idle;
  int                  resp_hold;
  int unsigned         mem_size;

  cma_req_if req_ch ();
  cma_rsp_if rsp_ch ();

  contiguous_memory_allocator_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  cma_alloc_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .rsp_i       (rsp_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 13);
  endfunction

  // response side: random stall after each accepted response
  always @(posedge clk_i or negedge rst_ni) begin
    int gap;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      resp_hold <= 0;
    end else if (!rsp_ch.ready) begin
      if (resp_hold == 0) rsp_ch.ready <= 1'b1;
      else resp_hold <= resp_hold - 1;
    end else if (rsp_ch.valid) begin
      gap = draw_gap();
      if (gap != 0) begin
        rsp_ch.ready <= 1'b0;
        resp_hold <= gap - 1;
      end
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= IdleLimit) begin
      $display("[contiguous_memory_allocator_top] ERROR");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // one request; called at a clock edge, returns at the edge it is accepted
  task automatic send_req(opcode_e op, logic [7:0] pid, logic [SizeBits-1:0] size,
                          fit_e fit);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= '{opcode: op, process_id: pid, request_size: size, fit_mode: fit};
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // write total_size while idle; the effective size is clamped
  task automatic set_mem_size(logic [SizeBits-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mem_size = (value == 0) ? 1 : (value > (1 << AddrBits) ? (1 << AddrBits) : value);
  endtask

  task automatic random_req();
    int unsigned pick, size;
    logic [7:0] pid;
    opcode_e op;
    pick = $urandom_range(0, 99);
    op = pick < 58 ? OP_REQUEST : pick < 90 ? OP_RELEASE : pick < 96 ? OP_COMPACT : OP_NONE;
    pid = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 65) size = $urandom_range(1, (mem_size / 6 > 1) ? mem_size / 6 : 1);
    else if (pick < 75) size = $urandom_range(1, 4);
    else if (pick < 85) size = $urandom_range(1, mem_size);
    else if (pick < 92) size = 0;
    else size = $urandom_range(0, (1 << SizeBits) - 1);
    send_req(op, pid, size[SizeBits-1:0], fit_e'($urandom_range(0, 3)));
  endtask

  initial begin
    logic [SizeBits-1:0] sizes[$];
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    no_idle = 0;
    mem_size = 1 << AddrBits;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes on the reset-sized memory
    send_req(OP_REQUEST, 8'd0, '0, FIT_FIRST);
    send_req(OP_REQUEST, 8'd1, '1, FIT_BEST);
    send_req(OP_REQUEST, 8'hFF, 21'(1 << AddrBits), FIT_WORST);
    send_req(OP_REQUEST, 8'd2, 21'd1, FIT_OTHER);
    send_req(OP_RELEASE, 8'd7, '0, FIT_FIRST);
    send_req(OP_RELEASE, 8'hFF, '0, FIT_FIRST);
    send_req(OP_COMPACT, 8'd0, '0, FIT_FIRST);
    send_req(OP_NONE, 8'hAA, '1, FIT_OTHER);

    // full table, fragmentation and compaction on a small memory
    set_mem_size(21'd1600);
    for (int i = 0; i < NumAllocs; i++) send_req(OP_REQUEST, 8'(i), 21'd100, FIT_FIRST);
    send_req(OP_REQUEST, 8'd20, 21'd1, FIT_FIRST);
    send_req(OP_RELEASE, 8'd2, '0, FIT_FIRST);
    send_req(OP_RELEASE, 8'd5, '0, FIT_FIRST);
    send_req(OP_REQUEST, 8'd21, 21'd150, FIT_BEST);
    send_req(OP_COMPACT, 8'd0, '0, FIT_FIRST);
    send_req(OP_REQUEST, 8'd21, 21'd150, FIT_WORST);

    // random phases over several memory sizes, extremes included
    sizes = '{21'd1, '1, 21'd0, 21'(1 << AddrBits), 21'd300, 21'd4096,
              21'($urandom_range(16, 2000)), 21'($urandom_range(2, 100000))};
    foreach (sizes[p]) begin
      set_mem_size(sizes[p]);
      for (int n = 0; n < RandomItems / sizes.size(); n++) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if (p == 4 && n == 60) wait_drained();
        random_req();
      end
    end
    no_idle = 0;

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("[contiguous_memory_allocator_top] OK");
    else $display("[contiguous_memory_allocator_top] ERROR");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+design
design/cma_pkg.sv
design/cma_stream_if.sv
design/cma_ram.sv
design/contiguous_memory_allocator_top.sv
tb/cma_alloc_checker.sv
tb/tb_contiguous_memory_allocator_top.sv
